// ===== rtl/sll_pkg.sv =====
// ----------------------------------------------------------------------------
// sll_pkg
// Shared types, widths and helpers for the cursor-array linked list engine.
// ----------------------------------------------------------------------------
package sll_pkg;

   localparam int SLOTS  = 128;
   localparam int IDX_W  = $clog2(SLOTS);
   localparam int POS_W  = 7;
   localparam int DATA_W = 32;
   localparam int LEN_W  = 7;
   localparam int SLOT_W = 7;
   localparam int CMP_W  = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;

   typedef logic [IDX_W-1:0] idx_type;

   localparam idx_type FREE_HEAD = '0;
   localparam idx_type DATA_HEAD = IDX_W'(SLOTS - 1);

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   typedef enum logic {
      FN_INSERT = 1'b0,
      FN_DELETE = 1'b1
   } func_type;

   // One access of the slot store: one link read, one link write and an
   // optional data write to the same slot as the link write.
   typedef struct packed {
      idx_type             rd_addr;
      logic                wr_en;
      idx_type             wr_addr;
      idx_type             wr_link;
      logic                dwr_en;
      logic [DATA_W-1:0]   dwr_data;
   } mem_req_type;

   // Link value of a slot that has not been written since reset: the free
   // chain runs 0, 1, 2, ... and the last free slot and the data head end
   // their chains with zero.
   function automatic idx_type rst_link(input idx_type i);
      idx_type r;
      if (i >= IDX_W'(SLOTS - 2)) begin
         r = '0;
      end else begin
         r = IDX_W'(i + 1'b1);
      end
      return r;
   endfunction

endpackage

// ===== rtl/sll_store.sv =====
// ----------------------------------------------------------------------------
// sll_store
// Slot store: link memory with per-slot valid bits and a data memory.
// ----------------------------------------------------------------------------
module sll_store
   import sll_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type mem_req,
   output idx_type     rd_link
);

   idx_type           link_mem [SLOTS];
   logic [DATA_W-1:0] data_mem [SLOTS];
   logic [SLOTS-1:0]  valid_ff;
   idx_type           rd_mem_ff;
   idx_type           rd_addr_ff;
   logic              rd_valid_ff;

   // A slot that was never written reads as its reset link.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_req.wr_en) begin
         valid_ff[mem_req.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         link_mem[mem_req.wr_addr] <= mem_req.wr_link;
      end
      rd_mem_ff   <= link_mem[mem_req.rd_addr];
      rd_addr_ff  <= mem_req.rd_addr;
      rd_valid_ff <= valid_ff[mem_req.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_req.dwr_en) begin
         data_mem[mem_req.wr_addr] <= mem_req.dwr_data;
      end
   end

   assign rd_link = rd_valid_ff ? rd_mem_ff : rst_link(rd_addr_ff);

endmodule

// ===== rtl/sll_ctrl.sv =====
// ----------------------------------------------------------------------------
// sll_ctrl
// Request sequencer: cursor walk, slot allocate/free and result register.
// ----------------------------------------------------------------------------
module sll_ctrl
   import sll_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_func,
   input  logic [POS_W-1:0]  req_position,
   input  logic [DATA_W-1:0] req_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [LEN_W-1:0]  rsp_length,
   output logic [SLOT_W-1:0] rsp_slot,
   output mem_req_type       mem_req,
   input  idx_type           rd_link
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_FREE_RD,
      S_FREE_CHK,
      S_WALK,
      S_INS_RD_FRESH,
      S_INS_WR_HEAD,
      S_INS_RD_PRED,
      S_INS_WR_FRESH,
      S_INS_WR_PRED,
      S_DEL_RD_PRED,
      S_DEL_RD_VICT,
      S_DEL_WR_PRED,
      S_DEL_RD_HEAD,
      S_DEL_WR_VICT,
      S_DEL_WR_HEAD,
      S_RESULT
   } state_type;

   state_type         state_ff, state_in;
   func_type          func_ff, func_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [DATA_W-1:0] value_ff, value_in;
   idx_type           count_ff, count_in;
   idx_type           cur_ff, cur_in;
   idx_type           fresh_ff, fresh_in;
   logic [POS_W-1:0]  step_ff, step_in;
   logic              pend_ff, pend_in;
   status_type        status_ff, status_in;
   idx_type           slot_ff, slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   idx_type           rsp_length_ff, rsp_length_in;
   idx_type           rsp_slot_ff, rsp_slot_in;

   idx_type           cur_c;
   logic              bad_pos;
   logic [CMP_W-1:0]  pos_w, cnt_w;

   assign cur_c = pend_ff ? rd_link : cur_ff;
   assign pos_w = CMP_W'(req_position);
   assign cnt_w = CMP_W'(count_ff);

   always_comb begin
      if (func_type'(req_func) == FN_INSERT) begin
         bad_pos = (req_position == '0) || (pos_w > cnt_w + 1'b1);
      end else begin
         bad_pos = (req_position == '0) || (pos_w > cnt_w);
      end
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      fresh_in      = fresh_ff;
      step_in       = step_ff;
      pend_in       = pend_ff;
      status_in     = status_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;
      rsp_slot_in   = rsp_slot_ff;

      mem_req          = '0;
      mem_req.dwr_data = value_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in   = func_type'(req_func);
               pos_in    = req_position;
               value_in  = req_value;
               status_in = ST_DONE;
               slot_in   = '0;
               cur_in    = DATA_HEAD;
               step_in   = POS_W'(1);
               pend_in   = 1'b0;
               if (bad_pos) begin
                  status_in = ST_BADPOS;
                  state_in  = S_RESULT;
               end else if (func_type'(req_func) == FN_INSERT) begin
                  state_in = S_FREE_RD;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_FREE_RD: begin
            mem_req.rd_addr = FREE_HEAD;
            state_in        = S_FREE_CHK;
         end
         S_FREE_CHK: begin
            if (rd_link == '0) begin
               status_in = ST_FULL;
               state_in  = S_RESULT;
            end else begin
               fresh_in = rd_link;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // One cursor hop per cycle; the read data of the last hop feeds
            // the address of the next.
            cur_in = cur_c;
            if (step_ff < pos_ff) begin
               mem_req.rd_addr = cur_c;
               step_in         = step_ff + 1'b1;
               pend_in         = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = (func_ff == FN_INSERT) ? S_INS_RD_FRESH : S_DEL_RD_PRED;
            end
         end
         S_INS_RD_FRESH: begin
            mem_req.rd_addr = fresh_ff;
            state_in        = S_INS_WR_HEAD;
         end
         S_INS_WR_HEAD: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = FREE_HEAD;
            mem_req.wr_link = rd_link;
            state_in        = S_INS_RD_PRED;
         end
         S_INS_RD_PRED: begin
            mem_req.rd_addr = cur_ff;
            state_in        = S_INS_WR_FRESH;
         end
         S_INS_WR_FRESH: begin
            mem_req.wr_en   = 1'b1;
            mem_req.dwr_en  = 1'b1;
            mem_req.wr_addr = fresh_ff;
            mem_req.wr_link = rd_link;
            state_in        = S_INS_WR_PRED;
         end
         S_INS_WR_PRED: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cur_ff;
            mem_req.wr_link = fresh_ff;
            count_in        = count_ff + 1'b1;
            slot_in         = fresh_ff;
            state_in        = S_RESULT;
         end
         S_DEL_RD_PRED: begin
            mem_req.rd_addr = cur_ff;
            state_in        = S_DEL_RD_VICT;
         end
         S_DEL_RD_VICT: begin
            fresh_in        = rd_link;
            mem_req.rd_addr = rd_link;
            state_in        = S_DEL_WR_PRED;
         end
         S_DEL_WR_PRED: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cur_ff;
            mem_req.wr_link = rd_link;
            state_in        = S_DEL_RD_HEAD;
         end
         S_DEL_RD_HEAD: begin
            mem_req.rd_addr = FREE_HEAD;
            state_in        = S_DEL_WR_VICT;
         end
         S_DEL_WR_VICT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = fresh_ff;
            mem_req.wr_link = rd_link;
            state_in        = S_DEL_WR_HEAD;
         end
         S_DEL_WR_HEAD: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = FREE_HEAD;
            mem_req.wr_link = fresh_ff;
            count_in        = count_ff - 1'b1;
            slot_in         = fresh_ff;
            state_in        = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_length_in = count_ff;
               rsp_slot_in   = slot_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      pos_ff        <= pos_in;
      value_ff      <= value_in;
      cur_ff        <= cur_in;
      fresh_ff      <= fresh_in;
      step_ff       <= step_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_length = LEN_W'(rsp_length_ff);
   assign rsp_slot   = SLOT_W'(rsp_slot_ff);

endmodule

// ===== rtl/static_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// static_linked_list_engine
// Cursor-array linked list: insert before or delete at a 1-based position.
// ----------------------------------------------------------------------------
// A request word (req_func, req_position, req_value) is taken when req_valid
// and req_ready are both high; an insert puts the value before the position
// and a delete removes the element there. Each request returns one response
// word: a status (done, bad position, no free slot), the list length after the
// request and the slot allocated or freed, or zero when nothing changed.
// A bad position goes straight to the response register, and an insert into a
// full list stops at the free-slot check. Otherwise the walk makes position-1
// hops through the registered link read port, one per cycle, and then settles;
// an insert has done its free-slot check before the walk, and either operation
// then updates the links and ends in the response register. One request is
// in flight; req_ready rises in the same cycle as rsp_valid. The response
// register lets the engine go on while a word waits; a stalled receiver
// holds it only once the next response is ready to be written. Reset
// rebuilds the free chain through per-slot valid bits; ready at once.
// ----------------------------------------------------------------------------
module static_linked_list_engine
   import sll_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_func,
   input  logic [POS_W-1:0]  req_position,
   input  logic [DATA_W-1:0] req_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [LEN_W-1:0]  rsp_length,
   output logic [SLOT_W-1:0] rsp_slot
);

   // Memory request from the sequencer and registered link read data back.
   mem_req_type mem_req;
   idx_type     rd_link;

   // The sequencer owns all control, the walk cursor and the response
   // register.
   sll_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_length   (rsp_length),
      .rsp_slot     (rsp_slot),
      .mem_req      (mem_req),
      .rd_link      (rd_link)
   );

   // The slot store holds the links of both chains and the data words.
   sll_store u_store (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_link (rd_link)
   );

endmodule

// ===== rtl/sll_checker.sv =====
// ----------------------------------------------------------------------------
// sll_checker
// Port-level checks for the linked list engine, bound to the top level.
// ----------------------------------------------------------------------------
module sll_checker
   import sll_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_status,
   input logic [LEN_W-1:0]  rsp_length,
   input logic [SLOT_W-1:0] rsp_slot
);

   // A stalled response word holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_length) && $stable(rsp_slot))
      else $error("response changed while stalled");

   // Only one request is in flight: the engine drops ready after taking one.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // A rejected request touches no slot.
   a_reject_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DONE) |-> rsp_slot == '0)
      else $error("rejected request reports a slot");

   // A completed request never hands out the free-chain head slot.
   a_done_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_DONE) |-> rsp_slot != '0)
      else $error("completed request reports slot zero");

   // The list never holds more elements than there are usable slots.
   a_len_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> CMP_W'(rsp_length) <= CMP_W'(SLOTS - 2))
      else $error("list length beyond slot count");

endmodule

bind static_linked_list_engine sll_checker u_sll_checker (.*);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cursor-array linked list engine.
// ----------------------------------------------------------------------------
// Every request word that the engine accepts is run through a local model of
// the slot array: a link table, a data table and an element counter. The
// model yields the status, length and slot that the engine has to answer
// with. These go into a queue in order. A separate process compares every
// response word with the oldest entry of that queue. The stimulus has three
// parts. A directed part covers the position edges and every operation. A
// fill and drain pass takes the list to full and back to empty. A long
// random part drifts the list length up and down with mostly well-formed
// positions and some noise. Both sides of the engine insert random idle
// cycles, except in stretches where idling is switched off.
// ----------------------------------------------------------------------------
module testbench
   import sll_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int TAIL_CYCLES  = 160;
   localparam int RANDOM_WORDS = 1420;
   localparam int REPORT_MAX   = 10;

   // One response word as the model predicts it.
   typedef struct {
      status_type        status;
      logic [LEN_W-1:0]  length;
      logic [SLOT_W-1:0] slot;
   } list_result_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_func;
   logic [POS_W-1:0]  req_position;
   logic [DATA_W-1:0] req_value;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [1:0]        rsp_status;
   logic [LEN_W-1:0]  rsp_length;
   logic [SLOT_W-1:0] rsp_slot;

   // Local copy of the engine state. Slot 0 heads the free chain and the
   // last slot heads the data list; a link of zero ends either chain.
   idx_type           slot_links [SLOTS];
   logic [DATA_W-1:0] slot_words [SLOTS];
   int                list_len;

   list_result_type   pending_results [$];
   int                mismatches;
   int                cycle_count;
   // When set, neither side inserts idle cycles.
   bit                steady;

   static_linked_list_engine uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_length   (rsp_length),
      .rsp_slot     (rsp_slot)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   // Guard against a hung handshake: the slowest legal run stays far below
   // this count.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Number of idle cycles before the next word on either side.
   function automatic int pick_gap();
      int n;
      n = steady ? 0 : int'($urandom_range(0, 7));
      return n;
   endfunction

   // Walks from the data head to the slot in front of a 1-based position.
   function automatic idx_type find_predecessor(input int pos);
      idx_type cur;
      cur = DATA_HEAD;
      for (int hop = 1; hop < pos; hop++) begin
         cur = slot_links[cur];
      end
      return cur;
   endfunction

   // Applies one request to the local state and returns the response that
   // the engine owes for it. The position check comes before the free-slot
   // check, and a rejected request leaves the state untouched.
   function automatic list_result_type apply_request(input func_type fn,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [DATA_W-1:0] val);
      list_result_type r;
      idx_type         pred;
      idx_type         node;
      r.status = ST_DONE;
      r.slot   = '0;
      if (fn == FN_INSERT) begin
         if (pos == 0 || int'(pos) > list_len + 1) begin
            r.status = ST_BADPOS;
         end else if (slot_links[FREE_HEAD] == '0) begin
            r.status = ST_FULL;
         end else begin
            pred                  = find_predecessor(int'(pos));
            node                  = slot_links[FREE_HEAD];
            slot_links[FREE_HEAD] = slot_links[node];
            slot_words[node]      = val;
            slot_links[node]      = slot_links[pred];
            slot_links[pred]      = node;
            list_len++;
            r.slot = SLOT_W'(node);
         end
      end else begin
         if (pos == 0 || int'(pos) > list_len) begin
            r.status = ST_BADPOS;
         end else begin
            pred                  = find_predecessor(int'(pos));
            node                  = slot_links[pred];
            slot_links[pred]      = slot_links[node];
            slot_links[node]      = slot_links[FREE_HEAD];
            slot_links[FREE_HEAD] = node;
            list_len--;
            r.slot = SLOT_W'(node);
         end
      end
      r.length = LEN_W'(list_len);
      return r;
   endfunction

   // Presents one request word after a random gap and holds it until the
   // engine takes it. The prediction is made at the accepting edge, so the
   // model always reflects every word the engine has seen. The task returns
   // at that edge with valid still high; at the following falling edge the next
   // call lowers it or presents its own word, and a pause lowers it.
   task automatic send_word(input func_type fn, input logic [POS_W-1:0] pos,
                            input logic [DATA_W-1:0] val);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= fn;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(apply_request(fn, pos, val));
   endtask

   // Stops sending and waits until every outstanding response has come back.
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Position edges on a short list: empty-list requests, insert at front,
   // end and middle, delete at front, end and middle, position zero and the
   // top position for both operations, and data words with extreme values.
   task automatic test_directed_edges();
      send_word(FN_DELETE, 7'd1,   32'h0000_0000);
      send_word(FN_INSERT, 7'd0,   32'h1234_5678);
      send_word(FN_INSERT, 7'd2,   32'h1234_5678);
      send_word(FN_INSERT, 7'd1,   32'h7FFF_FFFF);
      send_word(FN_INSERT, 7'd2,   32'h8000_0000);
      send_word(FN_INSERT, 7'd1,   32'h0000_0000);
      send_word(FN_INSERT, 7'd2,   32'hFFFF_FFFF);
      send_word(FN_INSERT, 7'd127, 32'hA5A5_5A5A);
      send_word(FN_INSERT, 7'd6,   32'h5A5A_A5A5);
      send_word(FN_DELETE, 7'd0,   32'hFFFF_FFFF);
      send_word(FN_DELETE, 7'd5,   32'h0000_0000);
      send_word(FN_DELETE, 7'd4,   32'hDEAD_BEEF);
      send_word(FN_DELETE, 7'd2,   32'h0000_0000);
      send_word(FN_DELETE, 7'd127, 32'h0000_0000);
      send_word(FN_DELETE, 7'd1,   32'h0000_0000);
      send_word(FN_INSERT, 7'd2,   32'h0F0F_0F0F);
      send_word(FN_DELETE, 7'd2,   32'h0000_0000);
      send_word(FN_DELETE, 7'd1,   32'h0000_0000);
      send_word(FN_DELETE, 7'd1,   32'h0000_0000);
   endtask

   // Fills every free slot, then checks the full-list answers: a valid
   // position reports no free slot, while a bad position still reports a
   // bad position first. The top position is exercised at full length,
   // and the list is then drained to empty from random positions.
   task automatic test_fill_and_drain();
      hold_until_drained();
      steady = 1'b1;
      while (list_len < SLOTS - 2) begin
         send_word(FN_INSERT, POS_W'($urandom_range(1, list_len + 1)), $urandom());
      end
      steady = 1'b0;
      send_word(FN_INSERT, 7'd127, $urandom());
      send_word(FN_INSERT, 7'd1,   $urandom());
      send_word(FN_INSERT, 7'd0,   $urandom());
      send_word(FN_DELETE, 7'd127, $urandom());
      send_word(FN_DELETE, 7'd126, $urandom());
      send_word(FN_INSERT, 7'd127, $urandom());
      send_word(FN_INSERT, 7'd126, $urandom());
      while (list_len > 0) begin
         send_word(FN_DELETE, POS_W'($urandom_range(1, list_len)), $urandom());
      end
   endtask

   // Long random run. Every 200 words the insert share is drawn anew, so the
   // list length wanders between empty and full; some phases run without idle
   // cycles. Most words carry a valid position, often the first or the last
   // one, and a few are plain noise. Halfway through, the sender pauses
   // until the engine has answered everything.
   task automatic test_random_traffic();
      int       sent;
      int       insert_pct;
      int       roll;
      int       top;
      int       pos;
      func_type fn;
      sent       = 0;
      insert_pct = 50;
      while (sent < RANDOM_WORDS) begin
         if (sent % 200 == 0) begin
            case ($urandom_range(0, 2))
               0: begin
                  insert_pct = 25;
               end
               1: begin
                  insert_pct = 50;
               end
               default: begin
                  insert_pct = 80;
               end
            endcase
            steady = ($urandom_range(0, 3) == 0);
         end
         if (sent == RANDOM_WORDS / 2) begin
            hold_until_drained();
         end
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            fn  = func_type'($urandom_range(0, 1));
            pos = $urandom_range(0, 127);
         end else begin
            fn  = ($urandom_range(0, 99) < insert_pct || list_len == 0) ?
                  FN_INSERT : FN_DELETE;
            top = (fn == FN_INSERT) ? list_len + 1 : list_len;
            if (roll < 16) begin
               pos = top;
            end else if (roll < 24) begin
               pos = 1;
            end else begin
               pos = $urandom_range(1, top);
            end
         end
         send_word(fn, POS_W'(pos), $urandom());
         sent++;
      end
      steady = 1'b0;
   endtask

   // Receiver: draws an idle count for every response word, then holds
   // ready high until the word is taken.
   initial begin : response_sink
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = pick_gap();
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Checks every response word against the oldest prediction. A word with
   // nothing waiting is a failure as well.
   always @(posedge clock) begin : response_check
      list_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("unexpected response word: status %0d length %0d slot %0d",
                        rsp_status, rsp_length, rsp_slot);
            end
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status || rsp_length !== want.length ||
                rsp_slot !== want.slot) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("mismatch (status/length/slot): expected %0d/%0d/%0d",
                           want.status, want.length, want.slot,
                           ", got %0d/%0d/%0d", rsp_status, rsp_length, rsp_slot);
               end
            end
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_func     = FN_INSERT;
      req_position = '0;
      req_value    = '0;
      mismatches   = 0;
      cycle_count  = 0;
      steady       = 1'b0;

      // The model starts from the reset state: the free chain runs through
      // slots 1 up to the one below the data head, and the list is empty.
      for (int i = 0; i < SLOTS; i++) begin
         slot_links[i] = idx_type'(i + 1);
         slot_words[i] = '0;
      end
      slot_links[SLOTS - 2] = '0;
      slot_links[DATA_HEAD] = '0;
      list_len = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_fill_and_drain();
      test_random_traffic();

      // Let the engine answer everything, then give it time to show any
      // stray word before the verdict.
      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sll_pkg.sv
rtl/sll_store.sv
rtl/sll_ctrl.sv
rtl/static_linked_list_engine.sv
rtl/sll_checker.sv
dv/testbench.sv
